/* rtl/double_ended_queue_unit_assert.svh */
// Assertion macros used by the double-ended queue RTL.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DEQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque assertion failed");

`endif

/* rtl/deq_pkg.sv */
// Types, operation codes and defaults for the double-ended queue.
package deq_pkg;

    localparam int DEPTH_DEFAULT      = 64;
    localparam int DATA_WIDTH_DEFAULT = 32;

    localparam logic [2:0] MODE_PUSH_BACK  = 3'd0;
    localparam logic [2:0] MODE_PUSH_FRONT = 3'd1;
    localparam logic [2:0] MODE_POP_BACK   = 3'd2;
    localparam logic [2:0] MODE_POP_FRONT  = 3'd3;
    localparam logic [2:0] MODE_CLEAR      = 3'd4;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] data_in;
    } t_deq_in;

    typedef struct packed {
        logic [31:0] front_value;
        logic [31:0] back_value;
        logic [6:0]  element_count;
        logic        is_empty;
        logic        is_full;
        logic        ignored;
    } t_deq_out;

endpackage

/* rtl/deq_ram.sv */
// Slot memory of the double-ended queue: one write port, two registered read ports.
module deq_ram #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]     i_wr_addr,
    input  logic [DATA_WIDTH-1:0]        i_wr_data,
    input  logic                         i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]     i_rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0]     i_rd_addr_b,
    output logic [DATA_WIDTH-1:0]        o_rd_data_a,
    output logic [DATA_WIDTH-1:0]        o_rd_data_b
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Reads return the contents from before a write in the same cycle.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data_a <= mem[i_rd_addr_a];
            o_rd_data_b <= mem[i_rd_addr_b];
        end
    end

endmodule

/* rtl/double_ended_queue_unit.sv */
// Bounded double-ended queue kept in a ring of memory slots.
//
// A command is taken when start is high and busy is low. The queue state is
// updated and the slot written at that edge, while the new front and back slots
// are read from the memory; busy then stays high for one cycle while the read
// data returns. The result word appears on o_result for exactly one cycle with
// o_valid high, registered from the read state, and cannot be held off. A new
// command may be issued in the cycle the previous result is shown; the block
// takes no new command while the registered slot memory read of the last one
// returns. Pops on an empty queue, pushes on a full queue and unused mode codes
// leave the state alone and report ignored. Empty queues report zero front and
// back values. No clearing pass is needed after reset.
module double_ended_queue_unit #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  deq_pkg::t_deq_in  i_cmd,
    output logic              busy,
    output logic              o_valid,
    output deq_pkg::t_deq_out o_result
);

    import deq_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    t_state          r_state;
    logic [IW-1:0]   r_head;
    logic [IW-1:0]   r_tail;
    logic [CW-1:0]   r_count;
    logic            r_skip;
    logic            r_fwd_front;
    logic            r_fwd_back;
    logic [DATA_WIDTH-1:0] r_wr_data;

    logic [IW-1:0]   n_head;
    logic [IW-1:0]   n_tail;
    logic [CW-1:0]   n_count;
    logic            n_skip;
    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [63:0]     in_wide;
    logic            accept;
    logic            full;
    logic            empty;
    logic [IW-1:0]   head_next;
    logic [IW-1:0]   head_prev;
    logic [IW-1:0]   tail_next;
    logic [IW-1:0]   tail_prev;
    logic [IW-1:0]   rd_front_addr;
    logic [IW-1:0]   rd_back_addr;
    logic [DATA_WIDTH-1:0] rd_front_data;
    logic [DATA_WIDTH-1:0] rd_back_data;
    logic [DATA_WIDTH-1:0] front_slot;
    logic [DATA_WIDTH-1:0] back_slot;
    logic [63:0]     front_wide;
    logic [63:0]     back_wide;
    t_deq_out        n_result;

    assign accept  = start && !busy;
    assign busy    = (r_state == ST_READ);
    assign full    = (r_count == CW'(DEPTH));
    assign empty   = (r_count == '0);
    assign in_wide = 64'(i_cmd.data_in);
    assign wr_data = in_wide[DATA_WIDTH-1:0];

    assign head_next = (r_head == IW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign head_prev = (r_head == '0) ? IW'(DEPTH - 1) : r_head - 1'b1;
    assign tail_next = (r_tail == IW'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
    assign tail_prev = (r_tail == '0) ? IW'(DEPTH - 1) : r_tail - 1'b1;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_skip  = 1'b0;
        wr_en   = 1'b0;
        wr_addr = r_tail;
        unique case (i_cmd.mode)
            MODE_PUSH_BACK: begin
                if (full) begin
                    n_skip = 1'b1;
                end else begin
                    wr_en   = accept;
                    wr_addr = r_tail;
                    n_tail  = tail_next;
                    n_count = r_count + 1'b1;
                end
            end
            MODE_PUSH_FRONT: begin
                if (full) begin
                    n_skip = 1'b1;
                end else begin
                    wr_en   = accept;
                    wr_addr = head_prev;
                    n_head  = head_prev;
                    n_count = r_count + 1'b1;
                end
            end
            MODE_POP_BACK: begin
                if (empty) begin
                    n_skip = 1'b1;
                end else begin
                    n_tail  = tail_prev;
                    n_count = r_count - 1'b1;
                end
            end
            MODE_POP_FRONT: begin
                if (empty) begin
                    n_skip = 1'b1;
                end else begin
                    n_head  = head_next;
                    n_count = r_count - 1'b1;
                end
            end
            MODE_CLEAR: begin
                n_head  = '0;
                n_tail  = '0;
                n_count = '0;
            end
            default: begin
                n_skip = 1'b1;
            end
        endcase
    end

    // The back element sits one slot before the updated tail.
    assign rd_front_addr = n_head;
    assign rd_back_addr  = (n_tail == '0) ? IW'(DEPTH - 1) : n_tail - 1'b1;

    deq_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ram (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_en     (accept),
        .i_rd_addr_a (rd_front_addr),
        .i_rd_addr_b (rd_back_addr),
        .o_rd_data_a (rd_front_data),
        .o_rd_data_b (rd_back_data)
    );

    // A slot written at the same edge it is read returns stale data, so the
    // pushed word is forwarded instead.
    assign front_slot = r_fwd_front ? r_wr_data : rd_front_data;
    assign back_slot  = r_fwd_back ? r_wr_data : rd_back_data;
    assign front_wide = 64'(front_slot);
    assign back_wide  = 64'(back_slot);

    always_comb begin
        n_result.front_value   = empty ? '0 : front_wide[31:0];
        n_result.back_value    = empty ? '0 : back_wide[31:0];
        n_result.element_count = 7'(r_count);
        n_result.is_empty      = empty;
        n_result.is_full       = full;
        n_result.ignored       = r_skip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_head      <= n_head;
                        r_tail      <= n_tail;
                        r_count     <= n_count;
                        r_skip      <= n_skip;
                        r_wr_data   <= wr_data;
                        r_fwd_front <= wr_en && (wr_addr == rd_front_addr);
                        r_fwd_back  <= wr_en && (wr_addr == rd_back_addr);
                        r_state     <= ST_READ;
                    end
                end
                ST_READ: begin
                    o_result <= n_result;
                    o_valid  <= 1'b1;
                    r_state  <= ST_IDLE;
                end
            endcase
        end
    end

`include "double_ended_queue_unit_assert.svh"

    `DEQ_ASSERT_NEXT(a_accept_then_busy, i_clk, i_rst_n, start && !busy, busy)
    `DEQ_ASSERT_NEXT(a_busy_then_result, i_clk, i_rst_n, busy, o_valid && !busy)
    `DEQ_ASSERT_NOW(a_count_in_range, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH))
    `DEQ_ASSERT_NOW(a_ends_meet, i_clk, i_rst_n, empty || full, r_head == r_tail)

endmodule
